FILE: src/hssp_pkg.sv
// Shared types and constants for the hunk symbol stream parser.
`timescale 1ns / 1ps

package hssp_pkg;

   // Fixed field widths
   localparam int WORD_W  = 32;
   localparam int BIDX_W  = 6;
   localparam int CSR_W   = 7;
   localparam int COUNT_W = 11;

   // Header magic and hunk type codes (low 24 bits of a type word)
   localparam logic [31:0] HEADER_MAGIC = 32'd1011;
   localparam logic [23:0] TYPE_CODE    = 24'd1001;
   localparam logic [23:0] TYPE_DATA    = 24'd1002;
   localparam logic [23:0] TYPE_BSS     = 24'd1003;
   localparam logic [23:0] TYPE_RELOC32 = 24'd1004;
   localparam logic [23:0] TYPE_SYMBOL  = 24'd1008;
   localparam logic [23:0] TYPE_DEBUG   = 24'd1009;
   localparam logic [23:0] TYPE_END     = 24'd1010;

   // Mask for code/data length words (memory flags in the top two bits)
   localparam logic [31:0] LEN_MASK = 32'h3FFF_FFFF;

   // Request opcodes
   typedef enum logic [1:0] {
      OPC_START = 2'd0,
      OPC_WORD  = 2'd1,
      OPC_LOAD  = 2'd2
   } opcode_type;

   // Classified command passed from front to back
   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_WORD,
      CMD_LOAD
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [WORD_W-1:0] word;
      logic [BIDX_W-1:0] base_index;
      logic              eof;
   } cmd_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_ADDR    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [WORD_W-1:0]  data;
      logic [WORD_W-1:0]  hunk_number;
      logic [COUNT_W-1:0] symbol_count;
      logic               saw_symbol_hunk;
      logic               saw_debug_hunk;
      logic               partial_dropped;
      logic               last;
   } rsp_type;

   // Parse phases
   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_NAMES,
      PH_NAMESKIP,
      PH_COUNT,
      PH_RANGE,
      PH_SIZES,
      PH_TYPE,
      PH_HLEN,
      PH_BODYSKIP,
      PH_RCOUNT,
      PH_RTARGET,
      PH_ROFFS,
      PH_SYMLEN,
      PH_SYMNAME,
      PH_SYMVALUE,
      PH_STOP
   } phase_type;

   // Kind of the pending hunk length word
   typedef enum logic [1:0] {
      LEN_CODE,
      LEN_BSS,
      LEN_DEBUG
   } len_kind_type;

endpackage

FILE: src/hunk_symbol_stream_parser_top.sv
// A request item is registered in the command queue; its result items are registered in
//   the result queue and presented from there.
// Throughput: one request item per cycle while req_stall is low; an item that yields two
//   results (a symbol word with end of file) queues both for the single result port.
// Hunk base loads and file starts yield no result and are taken at the same rate.
// Reset (synchronous, active high) clears queues, parse state and the CSR;
//   hunk base memory is not cleared.
`timescale 1ns / 1ps

module hunk_symbol_stream_parser_top #(
   parameter int MAX_HUNKS   = 64,
   parameter int MAX_SYMBOLS = 1024,
   parameter int NAME_WORDS  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [hssp_pkg::WORD_W-1:0]  req_word,
   input  logic [hssp_pkg::BIDX_W-1:0]  req_base_index,
   input  logic                         req_end_of_file,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [hssp_pkg::WORD_W-1:0]  rsp_data,
   output logic [hssp_pkg::WORD_W-1:0]  rsp_hunk_number,
   output logic [hssp_pkg::COUNT_W-1:0] rsp_symbol_count,
   output logic                         rsp_saw_symbol_hunk,
   output logic                         rsp_saw_debug_hunk,
   output logic                         rsp_partial_dropped,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hssp_pkg::CSR_W-1:0]   csr_data
);

   hssp_pkg::cmd_type cmd;
   logic              cmd_valid, cmd_pop;
   hssp_pkg::rsp_type res0, res1, rsp;
   logic [1:0]        res_n;
   logic              room;

   // CSR is always writable
   assign csr_ready = 1'b1;

   hssp_front #(
      .MAX_HUNKS (MAX_HUNKS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_word        (req_word),
      .req_base_index  (req_base_index),
      .req_end_of_file (req_end_of_file),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   hssp_back #(
      .MAX_HUNKS   (MAX_HUNKS),
      .MAX_SYMBOLS (MAX_SYMBOLS),
      .NAME_WORDS  (NAME_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (room),
      .res0      (res0),
      .res1      (res1),
      .res_n     (res_n)
   );

   hssp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .res0      (res0),
      .res1      (res1),
      .res_n     (res_n),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Result fields
   assign rsp_kind            = rsp.kind;
   assign rsp_data            = rsp.data;
   assign rsp_hunk_number     = rsp.hunk_number;
   assign rsp_symbol_count    = rsp.symbol_count;
   assign rsp_saw_symbol_hunk = rsp.saw_symbol_hunk;
   assign rsp_saw_debug_hunk  = rsp.saw_debug_hunk;
   assign rsp_partial_dropped = rsp.partial_dropped;
   assign rsp_last            = rsp.last;

endmodule

FILE: src/hssp_front.sv
// Front end: accepts request items, classifies them and queues commands.
`timescale 1ns / 1ps

module hssp_front #(
   parameter int MAX_HUNKS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic [hssp_pkg::WORD_W-1:0] req_word,
   input  logic [hssp_pkg::BIDX_W-1:0] req_base_index,
   input  logic                       req_end_of_file,
   output logic                       cmd_valid,
   output hssp_pkg::cmd_type          cmd,
   input  logic                       cmd_pop
);

   localparam int DEPTH = 2;

   hssp_pkg::cmd_type cls_cmd;
   logic              cls_keep;
   logic              push;
   logic [31:0]       bidx_ext;

   hssp_pkg::cmd_type q_mem [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign bidx_ext = 32'(req_base_index);

   // Classify: opcode 3 and out-of-range base loads produce nothing and are dropped
   always_comb begin
      cls_cmd.word       = req_word;
      cls_cmd.base_index = req_base_index;
      cls_cmd.eof        = req_end_of_file;
      cls_cmd.op         = hssp_pkg::CMD_WORD;
      cls_keep           = 1'b0;
      case (req_opcode)
         hssp_pkg::OPC_START: begin
            cls_cmd.op = hssp_pkg::CMD_CLEAR;
            cls_keep   = 1'b1;
         end
         hssp_pkg::OPC_WORD: begin
            cls_cmd.op = hssp_pkg::CMD_WORD;
            cls_keep   = 1'b1;
         end
         hssp_pkg::OPC_LOAD: begin
            cls_cmd.op = hssp_pkg::CMD_LOAD;
            cls_keep   = (bidx_ext < 32'(MAX_HUNKS));
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   // Command queue
   assign req_stall = (count_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall && cls_keep;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cls_cmd;
      end
   end

endmodule

FILE: src/hssp_back.sv
// Back end: hunk stream parser, hunk base memory and result generation.
`timescale 1ns / 1ps

module hssp_back #(
   parameter int MAX_HUNKS   = 64,
   parameter int MAX_SYMBOLS = 1024,
   parameter int NAME_WORDS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [hssp_pkg::CSR_W-1:0]  csr_data,
   input  logic                        cmd_valid,
   input  hssp_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   input  logic                        rsp_room,
   output hssp_pkg::rsp_type           res0,
   output hssp_pkg::rsp_type           res1,
   output logic [1:0]                  res_n
);

   localparam int HW    = (MAX_HUNKS > 1) ? $clog2(MAX_HUNKS) : 1;
   localparam int SYM_W = $clog2(MAX_SYMBOLS + 1);
   localparam int NP_W  = $clog2(NAME_WORDS + 1);

   // Parser state
   hssp_pkg::phase_type    phase_ff, phase_in, phase_step;
   hssp_pkg::len_kind_type len_kind_ff, len_kind_in;
   logic [31:0]      skip_ff, skip_in;
   logic             range_first_ff, range_first_in;
   logic [31:0]      cur_hunk_ff, cur_hunk_in;
   logic [31:0]      attach_ff, attach_in;
   logic [31:0]      sym_base_ff, sym_base_in;
   logic [31:0]      nwl_ff, nwl_in;
   logic [SYM_W-1:0] acc_ff, acc_in;
   logic [1:0]       flags_ff, flags_in;
   logic [NP_W-1:0]  pos_ff, pos_in;
   logic             kept_ff, kept_in;
   logic [hssp_pkg::CSR_W-1:0] loaded_cnt_ff;

   // Base lookup pipeline
   logic        pend_ff, pend_in;
   logic        base_ok_ff, base_ok_in;
   logic [31:0] base_rd_ff;
   logic        base_rd_en;
   logic [HW-1:0] rd_addr, wr_addr;
   logic [31:0] widx_ext;
   logic [31:0] hunk_bases_mem [MAX_HUNKS];

   // Helpers
   logic        take, is_word, is_clear;
   logic [31:0] w;
   logic [23:0] w_type;
   logic [31:0] skip_dec, nwl_dec, hlen_skip;
   logic        pos_lt, emit_name, emit_addr;
   logic [31:0] acc_ext;

   assign take     = cmd_valid && rsp_room;
   assign cmd_pop  = take;
   assign is_word  = take && (cmd.op == hssp_pkg::CMD_WORD);
   assign is_clear = take && (cmd.op == hssp_pkg::CMD_CLEAR);
   assign w        = cmd.word;
   assign w_type   = w[23:0];
   assign skip_dec = skip_ff - 32'd1;
   assign nwl_dec  = nwl_ff - 32'd1;
   assign pos_lt   = (32'(pos_ff) < 32'(NAME_WORDS));

   always_comb begin
      case (len_kind_ff)
         hssp_pkg::LEN_DEBUG: hlen_skip = w;
         hssp_pkg::LEN_CODE:  hlen_skip = w & hssp_pkg::LEN_MASK;
         default:             hlen_skip = 32'd0;
      endcase
   end

   // Next state
   always_comb begin
      phase_step     = phase_ff;
      len_kind_in    = len_kind_ff;
      skip_in        = skip_ff;
      range_first_in = range_first_ff;
      cur_hunk_in    = cur_hunk_ff;
      attach_in      = attach_ff;
      nwl_in         = nwl_ff;
      acc_in         = acc_ff;
      flags_in       = flags_ff;
      pos_in         = pos_ff;
      kept_in        = kept_ff;
      base_rd_en     = 1'b0;
      base_ok_in     = base_ok_ff;
      emit_name      = 1'b0;
      emit_addr      = 1'b0;

      if (is_word) begin
         case (phase_ff)
            hssp_pkg::PH_MAGIC: begin
               phase_step = (w == hssp_pkg::HEADER_MAGIC) ? hssp_pkg::PH_NAMES
                                                          : hssp_pkg::PH_STOP;
            end
            hssp_pkg::PH_NAMES: begin
               if (w == 32'd0) begin
                  phase_step = hssp_pkg::PH_COUNT;
               end else begin
                  skip_in    = w;
                  phase_step = hssp_pkg::PH_NAMESKIP;
               end
            end
            hssp_pkg::PH_NAMESKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) phase_step = hssp_pkg::PH_NAMES;
            end
            hssp_pkg::PH_COUNT: begin
               skip_in        = w;
               range_first_in = 1'b1;
               phase_step     = hssp_pkg::PH_RANGE;
            end
            hssp_pkg::PH_RANGE: begin
               if (range_first_ff) begin
                  cur_hunk_in    = w;
                  attach_in      = w;
                  range_first_in = 1'b0;
               end else begin
                  phase_step = (skip_ff == 32'd0) ? hssp_pkg::PH_TYPE
                                                  : hssp_pkg::PH_SIZES;
               end
            end
            hssp_pkg::PH_SIZES, hssp_pkg::PH_BODYSKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) phase_step = hssp_pkg::PH_TYPE;
            end
            hssp_pkg::PH_TYPE: begin
               if (w_type == hssp_pkg::TYPE_CODE || w_type == hssp_pkg::TYPE_DATA) begin
                  len_kind_in = hssp_pkg::LEN_CODE;
                  phase_step  = hssp_pkg::PH_HLEN;
               end else if (w_type == hssp_pkg::TYPE_BSS) begin
                  len_kind_in = hssp_pkg::LEN_BSS;
                  phase_step  = hssp_pkg::PH_HLEN;
               end else if (w_type == hssp_pkg::TYPE_DEBUG) begin
                  flags_in[1] = 1'b1;
                  len_kind_in = hssp_pkg::LEN_DEBUG;
                  phase_step  = hssp_pkg::PH_HLEN;
               end else if (w_type == hssp_pkg::TYPE_RELOC32) begin
                  phase_step = hssp_pkg::PH_RCOUNT;
               end else if (w_type == hssp_pkg::TYPE_SYMBOL) begin
                  flags_in[0] = 1'b1;
                  base_rd_en  = 1'b1;
                  base_ok_in  = (attach_ff < 32'(loaded_cnt_ff)) &&
                                (attach_ff < 32'(MAX_HUNKS));
                  phase_step  = hssp_pkg::PH_SYMLEN;
               end else if (w_type == hssp_pkg::TYPE_END) begin
                  phase_step = hssp_pkg::PH_TYPE;
               end else begin
                  phase_step = hssp_pkg::PH_STOP;
               end
            end
            hssp_pkg::PH_HLEN: begin
               skip_in = hlen_skip;
               if (len_kind_ff != hssp_pkg::LEN_DEBUG) begin
                  attach_in   = cur_hunk_ff;
                  cur_hunk_in = cur_hunk_ff + 32'd1;
               end
               phase_step = (hlen_skip == 32'd0) ? hssp_pkg::PH_TYPE
                                                 : hssp_pkg::PH_BODYSKIP;
            end
            hssp_pkg::PH_RCOUNT: begin
               if (w == 32'd0) begin
                  phase_step = hssp_pkg::PH_TYPE;
               end else begin
                  skip_in    = w;
                  phase_step = hssp_pkg::PH_RTARGET;
               end
            end
            hssp_pkg::PH_RTARGET: begin
               phase_step = hssp_pkg::PH_ROFFS;
            end
            hssp_pkg::PH_ROFFS: begin
               skip_in = skip_dec;
               if (skip_dec == 32'd0) phase_step = hssp_pkg::PH_RCOUNT;
            end
            hssp_pkg::PH_SYMLEN: begin
               if (w == 32'd0) begin
                  phase_step = hssp_pkg::PH_TYPE;
               end else begin
                  nwl_in     = w;
                  pos_in     = '0;
                  kept_in    = (32'(acc_ff) < 32'(MAX_SYMBOLS));
                  phase_step = hssp_pkg::PH_SYMNAME;
               end
            end
            hssp_pkg::PH_SYMNAME: begin
               emit_name = kept_ff && pos_lt;
               if (pos_lt) pos_in = pos_ff + NP_W'(1);
               nwl_in = nwl_dec;
               if (nwl_dec == 32'd0) phase_step = hssp_pkg::PH_SYMVALUE;
            end
            hssp_pkg::PH_SYMVALUE: begin
               if (kept_ff) begin
                  emit_addr = 1'b1;
                  acc_in    = acc_ff + SYM_W'(1);
               end
               kept_in    = 1'b0;
               phase_step = hssp_pkg::PH_SYMLEN;
            end
            default: begin
               phase_step = phase_ff;
            end
         endcase
         // End of file closes the stream
         if (cmd.eof) kept_in = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_step;
      if (is_word && cmd.eof) phase_in = hssp_pkg::PH_STOP;
   end

   // Symbol base: the lookup result in base_rd_ff is latched into sym_base_ff while pend_ff is set
   always_comb begin
      pend_in     = base_rd_en;
      sym_base_in = sym_base_ff;
      if (pend_ff) sym_base_in = base_ok_ff ? base_rd_ff : 32'd0;
      if (is_clear) begin
         pend_in     = 1'b0;
         sym_base_in = 32'd0;
      end
   end

   // Results
   assign acc_ext = 32'(acc_in);

   always_comb begin
      hssp_pkg::rsp_type main_r, sum_r;

      main_r.kind            = emit_addr ? hssp_pkg::KIND_ADDR : hssp_pkg::KIND_NAME;
      main_r.data            = emit_addr ? (sym_base_ff + w) : w;
      main_r.hunk_number     = attach_ff;
      main_r.symbol_count    = acc_ext[hssp_pkg::COUNT_W-1:0];
      main_r.saw_symbol_hunk = flags_in[0];
      main_r.saw_debug_hunk  = flags_in[1];
      main_r.partial_dropped = 1'b0;
      main_r.last            = !cmd.eof;

      sum_r.kind            = hssp_pkg::KIND_SUMMARY;
      sum_r.data            = 32'd0;
      sum_r.hunk_number     = 32'd0;
      sum_r.symbol_count    = acc_ext[hssp_pkg::COUNT_W-1:0];
      sum_r.saw_symbol_hunk = flags_in[0];
      sum_r.saw_debug_hunk  = flags_in[1];
      sum_r.partial_dropped = (phase_step == hssp_pkg::PH_SYMNAME) ||
                              (phase_step == hssp_pkg::PH_SYMVALUE);
      sum_r.last            = 1'b1;

      res0  = main_r;
      res1  = sum_r;
      res_n = 2'd0;
      if (is_word) begin
         if (emit_name || emit_addr) begin
            res_n = cmd.eof ? 2'd2 : 2'd1;
         end else if (cmd.eof) begin
            res0  = sum_r;
            res_n = 2'd1;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset || is_clear) begin
         phase_ff       <= hssp_pkg::PH_MAGIC;
         len_kind_ff    <= hssp_pkg::LEN_CODE;
         skip_ff        <= 32'd0;
         range_first_ff <= 1'b0;
         cur_hunk_ff    <= 32'd0;
         attach_ff      <= 32'd0;
         nwl_ff         <= 32'd0;
         acc_ff         <= '0;
         flags_ff       <= 2'd0;
         pos_ff         <= '0;
         kept_ff        <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         len_kind_ff    <= len_kind_in;
         skip_ff        <= skip_in;
         range_first_ff <= range_first_in;
         cur_hunk_ff    <= cur_hunk_in;
         attach_ff      <= attach_in;
         nwl_ff         <= nwl_in;
         acc_ff         <= acc_in;
         flags_ff       <= flags_in;
         pos_ff         <= pos_in;
         kept_ff        <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         base_ok_ff    <= 1'b0;
         sym_base_ff   <= 32'd0;
         loaded_cnt_ff <= '0;
      end else begin
         pend_ff     <= pend_in;
         base_ok_ff  <= base_ok_in;
         sym_base_ff <= sym_base_in;
         if (csr_we) loaded_cnt_ff <= csr_data;
      end
   end

   // Hunk base memory: one write port, one registered read port
   assign widx_ext = 32'(cmd.base_index);
   assign wr_addr  = widx_ext[HW-1:0];
   assign rd_addr  = attach_ff[HW-1:0];

   always_ff @(posedge clock) begin
      if (take && (cmd.op == hssp_pkg::CMD_LOAD)) begin
         hunk_bases_mem[wr_addr] <= w;
      end
      if (base_rd_en) begin
         base_rd_ff <= hunk_bases_mem[rd_addr];
      end
   end

endmodule

FILE: src/hssp_rsp_queue.sv
// Result queue: takes up to two result items per cycle, delivers one unless rsp_stall holds it.
`timescale 1ns / 1ps

module hssp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  hssp_pkg::rsp_type res0,
   input  hssp_pkg::rsp_type res1,
   input  logic [1:0]        res_n,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hssp_pkg::rsp_type rsp
);

   localparam int DEPTH = 4;

   hssp_pkg::rsp_type q_mem [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [1:0] wr_ptr_nx;

   // Room for two items keeps the back end free of result-count checks
   assign room      = (count_ff <= 3'(DEPTH - 2));
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp       = q_mem[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_nx = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + res_n;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(res_n) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_n != 2'd0) q_mem[wr_ptr_ff] <= res0;
      if (res_n == 2'd2) q_mem[wr_ptr_nx] <= res1;
   end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the hunk symbol stream parser: random hunk files against a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_HUNKS      = 64;
   localparam int MAX_SYMBOLS    = 1024;
   localparam int NAME_WORDS     = 8;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int FILE_BATCH     = 270;

   // Opcode outside the defined set; the block must ignore it
   localparam logic [1:0] OPC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]                  opcode;
      logic [hssp_pkg::WORD_W-1:0] word;
      logic [hssp_pkg::BIDX_W-1:0] base_index;
      logic                        eof;
   } stream_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid       = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_opcode      = 2'd0;
   logic [hssp_pkg::WORD_W-1:0]  req_word        = '0;
   logic [hssp_pkg::BIDX_W-1:0]  req_base_index  = '0;
   logic                         req_end_of_file = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall       = 1'b0;
   logic [1:0]                   rsp_kind;
   logic [hssp_pkg::WORD_W-1:0]  rsp_data;
   logic [hssp_pkg::WORD_W-1:0]  rsp_hunk_number;
   logic [hssp_pkg::COUNT_W-1:0] rsp_symbol_count;
   logic                         rsp_saw_symbol_hunk;
   logic                         rsp_saw_debug_hunk;
   logic                         rsp_partial_dropped;
   logic                         rsp_last;
   logic                         csr_valid       = 1'b0;
   logic                         csr_ready;
   logic [hssp_pkg::CSR_W-1:0]   csr_data        = '0;

   hunk_symbol_stream_parser_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_word            (req_word),
      .req_base_index      (req_base_index),
      .req_end_of_file     (req_end_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data            (rsp_data),
      .rsp_hunk_number     (rsp_hunk_number),
      .rsp_symbol_count    (rsp_symbol_count),
      .rsp_saw_symbol_hunk (rsp_saw_symbol_hunk),
      .rsp_saw_debug_hunk  (rsp_saw_debug_hunk),
      .rsp_partial_dropped (rsp_partial_dropped),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus backlog and expected symbol records
   stream_item_type   item_backlog[$];
   stream_item_type   item_on_bus;
   hssp_pkg::rsp_type symbol_records_due[$];
   int                items_queued   = 0;
   int                items_accepted = 0;
   int                mismatches     = 0;
   int                quiet_cycles   = 0;
   int                send_idle_pct  = 0;
   int                recv_idle_pct  = 0;
   bit                item_taken     = 1'b0;

   // Predictor copy of the parser state
   logic [hssp_pkg::WORD_W-1:0]  hunk_base_mem[MAX_HUNKS];
   logic [hssp_pkg::CSR_W-1:0]   csr_hunk_count = '0;
   hssp_pkg::phase_type          p_phase;
   hssp_pkg::len_kind_type       p_len_kind;
   logic [hssp_pkg::WORD_W-1:0]  p_skip;
   logic [hssp_pkg::WORD_W-1:0]  p_hdr_left;
   logic [hssp_pkg::WORD_W-1:0]  p_cur_hunk;
   logic [hssp_pkg::WORD_W-1:0]  p_att_hunk;
   logic [hssp_pkg::WORD_W-1:0]  p_sym_base;
   logic [hssp_pkg::WORD_W-1:0]  p_name_left;
   logic [hssp_pkg::COUNT_W-1:0] p_sym_count;
   logic                         p_saw_sym;
   logic                         p_saw_dbg;
   logic                         p_keep;
   int                           p_name_pos;

   task automatic clear_parse_state();
      p_phase     = hssp_pkg::PH_MAGIC;
      p_len_kind  = hssp_pkg::LEN_CODE;
      p_skip      = '0;
      p_hdr_left  = '0;
      p_cur_hunk  = '0;
      p_att_hunk  = '0;
      p_sym_base  = '0;
      p_name_left = '0;
      p_sym_count = '0;
      p_saw_sym   = 1'b0;
      p_saw_dbg   = 1'b0;
      p_keep      = 1'b0;
      p_name_pos  = 0;
   endtask

   initial clear_parse_state();

   function automatic hssp_pkg::rsp_type make_record(hssp_pkg::kind_type k,
                                                     logic [hssp_pkg::WORD_W-1:0] d,
                                                     logic [hssp_pkg::WORD_W-1:0] h,
                                                     logic partial);
      hssp_pkg::rsp_type r;
      r.kind            = k;
      r.data            = d;
      r.hunk_number     = h;
      r.symbol_count    = p_sym_count;
      r.saw_symbol_hunk = p_saw_sym;
      r.saw_debug_hunk  = p_saw_dbg;
      r.partial_dropped = partial;
      r.last            = 1'b0;
      return r;
   endfunction

   // Advance the parser by one accepted item and queue the symbol records it yields
   task automatic parse_stream_item(stream_item_type it);
      hssp_pkg::rsp_type           outs[$];
      hssp_pkg::rsp_type           rec;
      logic [hssp_pkg::WORD_W-1:0] w;
      logic [23:0]                 t;
      logic                        partial;
      w = it.word;
      t = w[23:0];
      if (it.opcode == hssp_pkg::OPC_START) begin
         clear_parse_state();
         return;
      end
      if (it.opcode == hssp_pkg::OPC_LOAD) begin
         hunk_base_mem[it.base_index] = w;
         return;
      end
      if (it.opcode != hssp_pkg::OPC_WORD) return;

      case (p_phase)
         hssp_pkg::PH_MAGIC: begin
            p_phase = (w == hssp_pkg::HEADER_MAGIC) ? hssp_pkg::PH_NAMES : hssp_pkg::PH_STOP;
         end
         hssp_pkg::PH_NAMES: begin
            if (w == 0) p_phase = hssp_pkg::PH_COUNT;
            else begin
               p_skip  = w;
               p_phase = hssp_pkg::PH_NAMESKIP;
            end
         end
         hssp_pkg::PH_NAMESKIP: begin
            p_skip = p_skip - 32'd1;
            if (p_skip == 0) p_phase = hssp_pkg::PH_NAMES;
         end
         hssp_pkg::PH_COUNT: begin
            p_skip     = w;
            p_hdr_left = 32'd2;
            p_phase    = hssp_pkg::PH_RANGE;
         end
         hssp_pkg::PH_RANGE: begin
            if (p_hdr_left == 2) begin
               p_cur_hunk = w;
               p_att_hunk = w;
            end
            p_hdr_left = p_hdr_left - 32'd1;
            if (p_hdr_left == 0)
               p_phase = (p_skip == 0) ? hssp_pkg::PH_TYPE : hssp_pkg::PH_SIZES;
         end
         hssp_pkg::PH_SIZES, hssp_pkg::PH_BODYSKIP: begin
            p_skip = p_skip - 32'd1;
            if (p_skip == 0) p_phase = hssp_pkg::PH_TYPE;
         end
         hssp_pkg::PH_TYPE: begin
            if (t == hssp_pkg::TYPE_CODE || t == hssp_pkg::TYPE_DATA) begin
               p_len_kind = hssp_pkg::LEN_CODE;
               p_phase    = hssp_pkg::PH_HLEN;
            end else if (t == hssp_pkg::TYPE_BSS) begin
               p_len_kind = hssp_pkg::LEN_BSS;
               p_phase    = hssp_pkg::PH_HLEN;
            end else if (t == hssp_pkg::TYPE_DEBUG) begin
               p_saw_dbg  = 1'b1;
               p_len_kind = hssp_pkg::LEN_DEBUG;
               p_phase    = hssp_pkg::PH_HLEN;
            end else if (t == hssp_pkg::TYPE_RELOC32) begin
               p_phase = hssp_pkg::PH_RCOUNT;
            end else if (t == hssp_pkg::TYPE_SYMBOL) begin
               p_saw_sym  = 1'b1;
               p_sym_base = (p_att_hunk < csr_hunk_count && p_att_hunk < MAX_HUNKS) ?
                            hunk_base_mem[p_att_hunk[hssp_pkg::BIDX_W-1:0]] : '0;
               p_phase    = hssp_pkg::PH_SYMLEN;
            end else if (t == hssp_pkg::TYPE_END) begin
               p_phase = hssp_pkg::PH_TYPE;
            end else begin
               p_phase = hssp_pkg::PH_STOP;
            end
         end
         hssp_pkg::PH_HLEN: begin
            if (p_len_kind == hssp_pkg::LEN_DEBUG) p_skip = w;
            else begin
               // bss has no payload; code/data length drops the memory flags
               p_skip     = (p_len_kind == hssp_pkg::LEN_CODE) ? (w & hssp_pkg::LEN_MASK)
                                                               : '0;
               p_att_hunk = p_cur_hunk;
               p_cur_hunk = p_cur_hunk + 32'd1;
            end
            p_phase = (p_skip == 0) ? hssp_pkg::PH_TYPE : hssp_pkg::PH_BODYSKIP;
         end
         hssp_pkg::PH_RCOUNT: begin
            if (w == 0) p_phase = hssp_pkg::PH_TYPE;
            else begin
               p_skip  = w;
               p_phase = hssp_pkg::PH_RTARGET;
            end
         end
         hssp_pkg::PH_RTARGET: p_phase = hssp_pkg::PH_ROFFS;
         hssp_pkg::PH_ROFFS: begin
            p_skip = p_skip - 32'd1;
            if (p_skip == 0) p_phase = hssp_pkg::PH_RCOUNT;
         end
         hssp_pkg::PH_SYMLEN: begin
            if (w == 0) p_phase = hssp_pkg::PH_TYPE;
            else begin
               p_name_left = w;
               p_name_pos  = 0;
               p_keep      = (p_sym_count < MAX_SYMBOLS);
               p_phase     = hssp_pkg::PH_SYMNAME;
            end
         end
         hssp_pkg::PH_SYMNAME: begin
            if (p_keep && p_name_pos < NAME_WORDS)
               outs.push_back(make_record(hssp_pkg::KIND_NAME, w, p_att_hunk, 1'b0));
            if (p_name_pos < NAME_WORDS) p_name_pos++;
            p_name_left = p_name_left - 32'd1;
            if (p_name_left == 0) p_phase = hssp_pkg::PH_SYMVALUE;
         end
         hssp_pkg::PH_SYMVALUE: begin
            if (p_keep) begin
               p_sym_count = p_sym_count + 11'd1;
               outs.push_back(make_record(hssp_pkg::KIND_ADDR, p_sym_base + w,
                                          p_att_hunk, 1'b0));
            end
            p_keep  = 1'b0;
            p_phase = hssp_pkg::PH_SYMLEN;
         end
         default: ;
      endcase

      // End of file: summary, then the parser stops until the next start
      if (it.eof) begin
         partial = (p_phase == hssp_pkg::PH_SYMNAME || p_phase == hssp_pkg::PH_SYMVALUE);
         outs.push_back(make_record(hssp_pkg::KIND_SUMMARY, '0, '0, partial));
         p_phase = hssp_pkg::PH_STOP;
         p_keep  = 1'b0;
      end
      if (outs.size() != 0) begin
         rec = outs[outs.size() - 1];
         rec.last = 1'b1;
         outs[outs.size() - 1] = rec;
      end
      foreach (outs[i]) symbol_records_due.push_back(outs[i]);
   endtask

   function automatic void check_field(string fname, logic [hssp_pkg::WORD_W-1:0] want,
                                       logic [hssp_pkg::WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
         mismatches++;
      end
   endfunction

   // Driver: next item at the falling edge once the current one is taken
   always @(negedge clock) begin
      if (!reset && (item_taken || !req_valid)) begin
         if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item_on_bus = item_backlog.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= item_on_bus.opcode;
            req_word        <= item_on_bus.word;
            req_base_index  <= item_on_bus.base_index;
            req_end_of_file <= item_on_bus.eof;
         end else begin
            req_valid <= 1'b0;
         end
      end
      item_taken = 1'b0;
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: predict on accepted items, check accepted results, watchdog
   always @(posedge clock) begin
      hssp_pkg::rsp_type want;
      bit                progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_valid && !req_stall) begin
            parse_stream_item(item_on_bus);
            item_taken = 1'b1;
            items_accepted++;
            progress = 1'b1;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            progress = 1'b1;
            if (symbol_records_due.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual kind %0d data %0h",
                        $time, rsp_kind, rsp_data);
               mismatches++;
            end else begin
               want = symbol_records_due.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("data", want.data, rsp_data);
               check_field("hunk_number", want.hunk_number, rsp_hunk_number);
               check_field("symbol_count", 32'(want.symbol_count), 32'(rsp_symbol_count));
               check_field("saw_symbol_hunk", 32'(want.saw_symbol_hunk),
                           32'(rsp_saw_symbol_hunk));
               check_field("saw_debug_hunk", 32'(want.saw_debug_hunk),
                           32'(rsp_saw_debug_hunk));
               check_field("partial_dropped", 32'(want.partial_dropped),
                           32'(rsp_partial_dropped));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (csr_valid && csr_ready === 1'b1) progress = 1'b1;
         quiet_cycles = progress ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: nothing accepted for %0d cycles", $time, quiet_cycles);
            $display("** hunk_symbol_stream_parser_top: FAILED **");
            $finish;
         end
      end
   end

   task automatic queue_item(logic [1:0] op, logic [hssp_pkg::WORD_W-1:0] w,
                             logic [hssp_pkg::BIDX_W-1:0] idx, logic eof);
      stream_item_type it;
      it.opcode     = op;
      it.word       = w;
      it.base_index = idx;
      it.eof        = eof;
      item_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic queue_word(logic [hssp_pkg::WORD_W-1:0] w);
      queue_item(hssp_pkg::OPC_WORD, w, 6'($urandom_range(0, 63)), 1'b0);
   endtask

   // Type word with random upper byte; only the low 24 bits are decoded
   function automatic logic [hssp_pkg::WORD_W-1:0] type_word(logic [23:0] code);
      logic [7:0] hi;
      hi = 8'($urandom_range(0, 255));
      return {hi, code};
   endfunction

   // Wait until all items are taken and all records are in, then let the pipe settle
   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_queued || symbol_records_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_hunk_count(logic [hssp_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_hunk_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One hunk file, mostly well formed, sometimes cut short or broken
   task automatic queue_random_file();
      logic [hssp_pkg::WORD_W-1:0] fw[$];
      int                          n, len, pick, i;
      bit                          with_eof;
      fw.push_back(($urandom_range(0, 19) == 0) ? $urandom() : hssp_pkg::HEADER_MAGIC);
      repeat ($urandom_range(0, 2)) begin
         n = $urandom_range(1, 3);
         fw.push_back(32'(n));
         repeat (n) fw.push_back($urandom());
      end
      fw.push_back('0);
      n = $urandom_range(0, 3);
      fw.push_back(32'(n));
      pick = $urandom_range(0, 9);
      fw.push_back(pick == 0 ? $urandom() : (pick == 1 ? 32'hFFFF_FFFF : $urandom_range(0, 3)));
      fw.push_back($urandom());
      repeat (n) fw.push_back($urandom());

      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            fw.push_back(type_word($urandom_range(0, 1) ? hssp_pkg::TYPE_CODE
                                                        : hssp_pkg::TYPE_DATA));
            n = $urandom_range(0, 3);
            fw.push_back({2'($urandom_range(0, 3)), 30'(n)});
            repeat (n) fw.push_back($urandom());
         end else if (pick < 22) begin
            fw.push_back(type_word(hssp_pkg::TYPE_BSS));
            fw.push_back($urandom());
         end else if (pick < 32) begin
            fw.push_back(type_word(hssp_pkg::TYPE_RELOC32));
            repeat ($urandom_range(0, 2)) begin
               n = $urandom_range(1, 3);
               fw.push_back(32'(n));
               fw.push_back($urandom_range(0, 3));
               repeat (n) fw.push_back($urandom());
            end
            fw.push_back('0);
         end else if (pick < 70) begin
            fw.push_back(type_word(hssp_pkg::TYPE_SYMBOL));
            repeat ($urandom_range(1, 4)) begin
               // some names run past the kept name words
               n = ($urandom_range(0, 4) == 0) ? $urandom_range(NAME_WORDS + 1, NAME_WORDS + 4)
                                               : $urandom_range(1, 3);
               fw.push_back(32'(n));
               repeat (n) fw.push_back($urandom());
               fw.push_back($urandom());
            end
            fw.push_back('0);
         end else if (pick < 80) begin
            fw.push_back(type_word(hssp_pkg::TYPE_DEBUG));
            n = $urandom_range(0, 3);
            fw.push_back(32'(n));
            repeat (n) fw.push_back($urandom());
         end else if (pick < 97) begin
            fw.push_back(type_word(hssp_pkg::TYPE_END));
         end else begin
            fw.push_back($urandom());
         end
      end

      with_eof = ($urandom_range(0, 9) != 0);
      len = fw.size();
      if ($urandom_range(0, 5) == 0) len = $urandom_range(1, fw.size());
      queue_item(hssp_pkg::OPC_START, $urandom(), 6'($urandom_range(0, 63)),
                 $urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++) begin
         // sprinkle base loads and unused opcodes into the stream
         if ($urandom_range(0, 29) == 0)
            queue_item($urandom_range(0, 1) ? hssp_pkg::OPC_LOAD : OPC_UNUSED, $urandom(),
                       6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         queue_item(hssp_pkg::OPC_WORD, fw[i], 6'($urandom_range(0, 63)),
                    with_eof && i == len - 1);
      end
      // stray words after end of file are not parsed; one flagged end of file yields a summary
      if (with_eof && $urandom_range(0, 7) == 0)
         queue_item(hssp_pkg::OPC_WORD, $urandom(), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)));
   endtask

   task automatic queue_random_files(int target);
      int first;
      first = items_queued;
      while (items_queued - first < target) queue_random_file();
   endtask

   initial begin
      logic [hssp_pkg::WORD_W-1:0] first_file[20];
      int                          i;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 72;
      write_hunk_count('0);

      // Directed: unused opcode, ignored end flags, header with wrapping hunk index,
      // flagged code length, reloc list, symbols, end of file inside an entry
      queue_item(OPC_UNUSED, $urandom(), '0, 1'b1);
      queue_item(hssp_pkg::OPC_LOAD, 32'hFFFF_FFFF, 6'd63, 1'b1);
      queue_item(hssp_pkg::OPC_START, '0, '0, 1'b1);
      first_file = '{hssp_pkg::HEADER_MAGIC, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0,
                     {8'hFF, hssp_pkg::TYPE_CODE}, 32'hC000_0001, 32'd0,
                     {8'h00, hssp_pkg::TYPE_RELOC32}, 32'd1, 32'd0, 32'd0, 32'd0,
                     {8'h00, hssp_pkg::TYPE_SYMBOL}, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'd2, 32'hAAAA_AAAA};
      foreach (first_file[k]) queue_word(first_file[k]);
      // hold the sender until everything so far has come back
      wait_drained();
      queue_item(hssp_pkg::OPC_WORD, 32'h5555_5555, '0, 1'b1);
      queue_word(32'd7);
      queue_item(hssp_pkg::OPC_START, '0, '0, 1'b0);
      queue_word(32'd0);
      queue_item(hssp_pkg::OPC_WORD, hssp_pkg::HEADER_MAGIC, '0, 1'b1);

      // Load every hunk base before any lookup can reach one
      for (i = 0; i < MAX_HUNKS; i++) queue_item(hssp_pkg::OPC_LOAD, $urandom(), 6'(i), 1'b0);
      queue_random_files(FILE_BATCH);
      wait_drained();

      write_hunk_count(7'd64);
      queue_random_files(FILE_BATCH);
      wait_drained();

      send_idle_pct = 72;
      recv_idle_pct = 29;
      write_hunk_count(7'($urandom_range(1, 63)));
      queue_random_files(FILE_BATCH);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_hunk_count(7'd64);
      queue_random_files(FILE_BATCH);
      wait_drained();

      if (mismatches == 0 && symbol_records_due.size() == 0) begin
         $display("** hunk_symbol_stream_parser_top: PASSED **");
      end else begin
         $display("** hunk_symbol_stream_parser_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/hssp_pkg.sv
src/hssp_front.sv
src/hssp_back.sv
src/hssp_rsp_queue.sv
src/hunk_symbol_stream_parser_top.sv
verif/testbench.sv
